// ===== design/speech_mouth_shape_classifier_macros.svh =====
// Assertion macros for the mouth-shape classifier.
// Included by the top level; no other dependencies.
`ifndef SPEECH_MOUTH_SHAPE_CLASSIFIER_MACROS_SVH
`define SPEECH_MOUTH_SHAPE_CLASSIFIER_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define SMSC_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("smsc: same-cycle check failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define SMSC_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("smsc: next-cycle check failed");
`else
`define SMSC_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define SMSC_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif
`endif

// ===== design/smsc_pkg.sv =====
// Shared types, constants and codes for the mouth-shape classifier.
// No dependencies; imported by every file but the macro header.
package smsc_pkg;

  // Field widths.
  localparam int MAG_W      = 16;
  localparam int SAMPLE_W   = 16;
  localparam int WL_W       = 13;
  localparam int THR_W      = 15;
  localparam int REF_W      = 15;
  localparam int POS_W      = 3;
  localparam int MEAN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Default maximum window length.
  localparam int MAX_WINDOW_DEFAULT = 4096;

  // Register reset values.
  localparam logic             FORMAT_RESET  = 1'b1;
  localparam logic [WL_W-1:0]  WINDOW_RESET  = 13'd1378;
  localparam logic [THR_W-1:0] CLOSED_RESET  = 15'd819;
  localparam logic [THR_W-1:0] BIG_RESET     = 15'd5734;
  localparam logic [THR_W-1:0] SHOUT_RESET   = 15'd11469;
  localparam logic [REF_W-1:0] REF_DEV_RESET = 15'd0;

  // Sample formats.
  localparam logic FORMAT_U8  = 1'b0;

  // Unsigned 8-bit samples: offset and scale to Q1.15.
  localparam logic [7:0]       U8_BIAS  = 8'd127;
  localparam logic [MAG_W-1:0] U8_SCALE = 16'd258;

  // Mouth position codes.
  localparam logic [POS_W-1:0] POS_CLOSED   = 3'd0;
  localparam logic [POS_W-1:0] POS_SMALL_OH = 3'd1;
  localparam logic [POS_W-1:0] POS_SMALL_EE = 3'd2;
  localparam logic [POS_W-1:0] POS_BIG_OH   = 3'd3;
  localparam logic [POS_W-1:0] POS_BIG_EE   = 3'd4;
  localparam logic [POS_W-1:0] POS_SHOUT    = 3'd5;

  // Register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_FORMAT = 3'd0,
    CFG_WINDOW_LENGTH = 3'd1,
    CFG_CLOSED        = 3'd2,
    CFG_BIG           = 3'd3,
    CFG_SHOUT         = 3'd4,
    CFG_REF_DEV       = 3'd5
  } cfg_index_t;

  // Current register contents.
  typedef struct packed {
    logic             sample_format;
    logic [WL_W-1:0]  window_length;
    logic [THR_W-1:0] closed_threshold;
    logic [THR_W-1:0] big_threshold;
    logic [THR_W-1:0] shout_threshold;
    logic [REF_W-1:0] reference_deviation;
  } cfg_t;

  // Operand choice for the shared multiplier.
  typedef enum logic [1:0] {
    MUL_SEL_LHS   = 2'd0,
    MUL_SEL_SQ    = 2'd1,
    MUL_SEL_REF   = 2'd2,
    MUL_SEL_CHAIN = 2'd3
  } mul_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     accum;
    logic     close_window;
    logic     div_step;
    logic     mul_load;
    mul_sel_t mul_sel;
    logic     mul_step;
    logic     store_lhs;
    logic     store_spread;
    logic     store_rhs;
    logic     scale;
    logic     out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic win_end;
    logic div_done;
    logic mul_done;
  } status_t;

endpackage

// ===== design/smsc_sample_if.sv =====
// Sample input channel: valid/ready handshake with one audio sample.
// Depends on smsc_pkg.
interface smsc_sample_if;
  import smsc_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       clip_start;

  modport source (output valid, output sample_value, output clip_start, input ready);
  modport sink (input valid, input sample_value, input clip_start, output ready);
endinterface

// ===== design/smsc_mouth_if.sv =====
// Result channel: valid/ready handshake with one mouth position and window mean.
// Depends on smsc_pkg.
interface smsc_mouth_if;
  import smsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  mouth_position;
  logic [MEAN_W-1:0] window_mean;

  modport source (output valid, output mouth_position, output window_mean, input ready);
  modport sink (input valid, input mouth_position, input window_mean, output ready);
endinterface

// ===== design/smsc_cfg_if.sv =====
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on smsc_pkg.
interface smsc_cfg_if;
  import smsc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/smsc_regs.sv =====
// Configuration register file of the mouth-shape classifier.
// Depends on smsc_pkg and smsc_cfg_if.
module smsc_regs (
  input  logic          clk,
  input  logic          rst,
  smsc_cfg_if.sink      cfg,
  output smsc_pkg::cfg_t regs
);
  import smsc_pkg::*;

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // One transaction writes one register; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sample_format       <= FORMAT_RESET;
      regs.window_length       <= WINDOW_RESET;
      regs.closed_threshold    <= CLOSED_RESET;
      regs.big_threshold       <= BIG_RESET;
      regs.shout_threshold     <= SHOUT_RESET;
      regs.reference_deviation <= REF_DEV_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SAMPLE_FORMAT: regs.sample_format       <= cfg.data[0];
        CFG_WINDOW_LENGTH: regs.window_length       <= cfg.data[WL_W-1:0];
        CFG_CLOSED:        regs.closed_threshold    <= cfg.data[THR_W-1:0];
        CFG_BIG:           regs.big_threshold       <= cfg.data[THR_W-1:0];
        CFG_SHOUT:         regs.shout_threshold     <= cfg.data[THR_W-1:0];
        CFG_REF_DEV:       regs.reference_deviation <= cfg.data[REF_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== design/smsc_ctrl.sv =====
// Controller of the mouth-shape classifier: sequences accumulation, the
// division, the multiplier runs and the result hand-off. Depends on smsc_pkg.
module smsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  smsc_pkg::status_t status,
  output smsc_pkg::cmd_t    cmd
);
  import smsc_pkg::*;

  typedef enum logic [8:0] {
    ST_ACCUM  = 9'b000000001,
    ST_DIVIDE = 9'b000000010,
    ST_MUL_LHS = 9'b000000100,
    ST_MUL_SQ = 9'b000001000,
    ST_MUL_REF = 9'b000010000,
    ST_MUL_N1 = 9'b000100000,
    ST_MUL_N2 = 9'b001000000,
    ST_SCALE  = 9'b010000000,
    ST_EMIT   = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready = (state == ST_ACCUM);
  assign accept   = in_valid && in_ready;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.mul_sel = MUL_SEL_LHS;
    unique case (state)
      ST_ACCUM: begin
        if (accept) begin
          cmd.accum = 1'b1;
          if (status.win_end) begin
            cmd.close_window = 1'b1;
            state_next       = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          cmd.mul_load = 1'b1;
          cmd.mul_sel  = MUL_SEL_LHS;
          state_next   = ST_MUL_LHS;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_MUL_LHS: begin
        if (status.mul_done) begin
          cmd.store_lhs = 1'b1;
          cmd.mul_load  = 1'b1;
          cmd.mul_sel   = MUL_SEL_SQ;
          state_next    = ST_MUL_SQ;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_MUL_SQ: begin
        if (status.mul_done) begin
          cmd.store_spread = 1'b1;
          cmd.mul_load     = 1'b1;
          cmd.mul_sel      = MUL_SEL_REF;
          state_next       = ST_MUL_REF;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_MUL_REF: begin
        if (status.mul_done) begin
          cmd.mul_load = 1'b1;
          cmd.mul_sel  = MUL_SEL_CHAIN;
          state_next   = ST_MUL_N1;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_MUL_N1: begin
        if (status.mul_done) begin
          cmd.mul_load = 1'b1;
          cmd.mul_sel  = MUL_SEL_CHAIN;
          state_next   = ST_MUL_N2;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_MUL_N2: begin
        if (status.mul_done) begin
          cmd.store_rhs = 1'b1;
          state_next    = ST_SCALE;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      ST_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACCUM;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/smsc_datapath.sv =====
// Datapath of the mouth-shape classifier: rectifier, window accumulators,
// bit-serial divider, shared shift-add multiplier and output register.
// Depends on smsc_pkg.
module smsc_datapath #(
  parameter int MAX_WINDOW = smsc_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [smsc_pkg::SAMPLE_W-1:0] sample_value,
  input  logic                               clip_start,
  input  smsc_pkg::cfg_t                     regs,
  input  smsc_pkg::cmd_t                     cmd,
  output smsc_pkg::status_t                  status,
  output logic [smsc_pkg::POS_W-1:0]         mouth_position,
  output logic [smsc_pkg::MEAN_W-1:0]        window_mean
);
  import smsc_pkg::*;

  localparam int CNT_W  = $clog2(MAX_WINDOW);
  localparam int NW     = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (NW > WL_W) ? NW : WL_W;
  localparam int SUM_W  = CNT_W + MAG_W;
  localparam int SQ_W   = CNT_W + 2 * MAG_W;
  localparam int LHS_W  = NW + SQ_W;
  localparam int RHS_W  = 2 * REF_W + 2 * NW;
  localparam int PW     = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int SW     = PW + 6;
  localparam int DC_W   = $clog2(SUM_W + 1);

  // Window accumulators.
  logic [CNT_W-1:0] count;
  logic [SUM_W-1:0] sum;
  logic [SQ_W-1:0]  sqsum;

  // Snapshots of a closed window and the divider.
  logic [SUM_W-1:0] s_snap;
  logic [SQ_W-1:0]  q_snap;
  logic [SUM_W-1:0] quo;
  logic [NW-1:0]    rem;
  logic [DC_W-1:0]  div_cnt;

  // Shared multiplier and variance terms.
  logic [PW-1:0]    mul_a;
  logic [SUM_W-1:0] mul_b;
  logic [PW-1:0]    mul_acc;
  logic [PW-1:0]    lhs;
  logic [PW-1:0]    spread;
  logic [PW-1:0]    rhs;
  logic [SW-1:0]    spread36;
  logic [SW-1:0]    rhs25;

  // Combinational terms.
  logic [MAG_W-1:0]   raw;
  logic [7:0]         u8_dist;
  logic [MAG_W-1:0]   mag;
  logic [2*MAG_W-1:0] mag_sq;
  logic [CNT_W-1:0]   count_base;
  logic [SUM_W-1:0]   sum_base;
  logic [SQ_W-1:0]    sq_base;
  logic [CNT_W:0]     count_inc;
  logic [SUM_W-1:0]   sum_new;
  logic [SQ_W-1:0]    sq_new;
  logic [CMP_W-1:0]   wl_ext;
  logic [CMP_W-1:0]   n_wide;
  logic [NW-1:0]      n;
  logic [NW:0]        trial;
  logic               trial_ge;
  logic               var_up;
  logic [POS_W-1:0]   pos;

  // Rectify the sample to a Q1.15 magnitude.
  assign raw     = sample_value;
  assign u8_dist = (raw[7:0] >= U8_BIAS) ? (raw[7:0] - U8_BIAS) : (U8_BIAS - raw[7:0]);
  always_comb begin
    if (regs.sample_format == FORMAT_U8) begin
      mag = MAG_W'(u8_dist) * U8_SCALE;
    end else if (raw[MAG_W-1]) begin
      mag = ~raw + MAG_W'(1);
    end else begin
      mag = raw;
    end
  end
  assign mag_sq = (2*MAG_W)'(mag) * (2*MAG_W)'(mag);

  // Effective window length: zero reads as one, long values saturate.
  assign wl_ext = CMP_W'(regs.window_length);
  always_comb begin
    if (wl_ext == '0) begin
      n_wide = CMP_W'(1);
    end else if (wl_ext > CMP_W'(MAX_WINDOW)) begin
      n_wide = CMP_W'(MAX_WINDOW);
    end else begin
      n_wide = wl_ext;
    end
  end
  assign n = n_wide[NW-1:0];

  // Accumulate, clearing first at the start of a clip.
  assign count_base     = clip_start ? '0 : count;
  assign sum_base       = clip_start ? '0 : sum;
  assign sq_base        = clip_start ? '0 : sqsum;
  assign count_inc      = {1'b0, count_base} + (CNT_W+1)'(1);
  assign sum_new        = sum_base + SUM_W'(mag);
  assign sq_new         = sq_base + SQ_W'(mag_sq);
  assign status.win_end = (count_inc >= (CNT_W+1)'(n));

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      sum   <= '0;
      sqsum <= '0;
    end else if (cmd.accum) begin
      if (cmd.close_window) begin
        count <= '0;
        sum   <= '0;
        sqsum <= '0;
      end else begin
        count <= count_inc[CNT_W-1:0];
        sum   <= sum_new;
        sqsum <= sq_new;
      end
    end
  end

  // Restoring divider, one quotient bit a cycle; the quotient shifts in
  // behind the dividend.
  assign trial           = {rem, quo[SUM_W-1]};
  assign trial_ge        = (trial >= {1'b0, n});
  assign status.div_done = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (cmd.close_window) begin
      s_snap  <= sum_new;
      q_snap  <= sq_new;
      quo     <= sum_new;
      rem     <= '0;
      div_cnt <= DC_W'(SUM_W);
    end else if (cmd.div_step) begin
      rem     <= trial_ge ? NW'(trial - {1'b0, n}) : trial[NW-1:0];
      quo     <= {quo[SUM_W-2:0], trial_ge};
      div_cnt <= div_cnt - DC_W'(1);
    end
  end

  // Shift-add multiplier, one multiplier bit a cycle, done when no bits remain.
  assign status.mul_done = (mul_b == '0);

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      mul_acc <= '0;
      unique case (cmd.mul_sel)
        MUL_SEL_LHS: begin
          mul_a <= PW'(q_snap);
          mul_b <= SUM_W'(n);
        end
        MUL_SEL_SQ: begin
          mul_a <= PW'(s_snap);
          mul_b <= s_snap;
        end
        MUL_SEL_REF: begin
          mul_a <= PW'(regs.reference_deviation);
          mul_b <= SUM_W'(regs.reference_deviation);
        end
        MUL_SEL_CHAIN: begin
          mul_a <= mul_acc;
          mul_b <= SUM_W'(n);
        end
      endcase
    end else if (cmd.mul_step) begin
      if (mul_b[0]) begin
        mul_acc <= mul_acc + mul_a;
      end
      mul_a <= {mul_a[PW-2:0], 1'b0};
      mul_b <= {1'b0, mul_b[SUM_W-1:1]};
    end
  end

  // Variance terms: N*sqsum, the clamped spread, and the scaled reference.
  always_ff @(posedge clk) begin
    if (cmd.store_lhs) begin
      lhs <= mul_acc;
    end
    if (cmd.store_spread) begin
      spread <= (lhs > mul_acc) ? (lhs - mul_acc) : '0;
    end
    if (cmd.store_rhs) begin
      rhs <= mul_acc;
    end
    if (cmd.scale) begin
      spread36 <= SW'({spread, 5'b0}) + SW'({spread, 2'b0});
      rhs25    <= SW'({rhs, 4'b0}) + SW'({rhs, 3'b0}) + SW'(rhs);
    end
  end

  // Position from the mean and the variance test.
  assign var_up = (spread36 > rhs25);
  always_comb begin
    if (quo < SUM_W'(regs.closed_threshold)) begin
      pos = POS_CLOSED;
    end else if (quo > SUM_W'(regs.shout_threshold)) begin
      pos = POS_SHOUT;
    end else if (quo > SUM_W'(regs.big_threshold)) begin
      pos = var_up ? POS_BIG_EE : POS_BIG_OH;
    end else begin
      pos = var_up ? POS_SMALL_EE : POS_SMALL_OH;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mouth_position <= pos;
      window_mean    <= quo[MEAN_W-1:0];
    end
  end

endmodule

// ===== design/speech_mouth_shape_classifier.sv =====
// Mouth-shape classifier: takes one audio sample per cycle while a window
// fills; the sample that closes a window starts its decision (a bit-serial
// divide of the sum, then five runs of a shared shift-add multiplier that
// takes one multiplier bit at a time, then a scale and a compare). No sample
// is taken during that time; the result then waits in an output register
// while the next window fills.
// Depends on smsc_pkg, the channel interfaces, smsc_regs, smsc_ctrl,
// smsc_datapath and the assertion macro header.
`include "speech_mouth_shape_classifier_macros.svh"

module speech_mouth_shape_classifier #(
  parameter int MAX_WINDOW = smsc_pkg::MAX_WINDOW_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  smsc_sample_if.sink   sample,
  smsc_mouth_if.source  mouth,
  smsc_cfg_if.sink      cfg
);
  import smsc_pkg::*;

  cfg_t    regs;
  cmd_t    cmd;
  status_t status;

  // Configuration registers.
  smsc_regs u_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Sequencer.
  smsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .out_valid (mouth.valid),
    .out_ready (mouth.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic.
  smsc_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .sample_value   (sample.sample_value),
    .clip_start     (sample.clip_start),
    .regs           (regs),
    .cmd            (cmd),
    .status         (status),
    .mouth_position (mouth.mouth_position),
    .window_mean    (mouth.window_mean)
  );

  // A closing sample stops further samples while the decision runs.
  `SMSC_ASSERT_NEXT(a_close_stalls_input, clk, rst, sample.valid && sample.ready && cmd.close_window, !sample.ready)
  // A result is only loaded when the output register is free or draining.
  `SMSC_ASSERT_IMPLIES(a_load_when_free, clk, rst, cmd.out_load, !mouth.valid || mouth.ready)
  // A presented position is always a defined mouth shape.
  `SMSC_ASSERT_IMPLIES(a_position_defined, clk, rst, mouth.valid, mouth.mouth_position <= POS_SHOUT)

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the mouth-shape classifier: drives audio samples and
// register writes through the channel interfaces and checks every window's result.
// Depends on smsc_pkg, the sample, mouth and cfg interfaces and the top level.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import smsc_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int MAX_N          = MAX_WINDOW_DEFAULT;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_ITEMS   = 1650;
  localparam int LONG_PROBE     = 30;

  localparam logic                  FORMAT_S16  = ~FORMAT_U8;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0]  CFG_SPARE_B = 3'd7;

  localparam logic [SAMPLE_W-1:0] WIDE_EXTREMES [7] = '{
    16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h4000, 16'h4001
  };
  localparam logic [SAMPLE_W-1:0] BYTE_EXTREMES [6] = '{
    16'h0000, 16'h007F, 16'h00FF, 16'h0080, 16'hAB7F, 16'hFF00
  };

  typedef struct packed {
    logic [POS_W-1:0]  position;
    logic [MEAN_W-1:0] mean;
  } shape_t;

  // Tracks the window accumulators and holds the shapes still owed by the block.
  class mouth_shape_checker;
    cfg_t      regs;
    int        taken;
    bit [29:0] mag_sum;
    bit [45:0] mag_sq_sum;
    shape_t    pending_shapes[$];
    int        errors;
    int        windows_closed;
    int        position_hits[6];

    function new();
      regs.sample_format       = FORMAT_RESET;
      regs.window_length       = WINDOW_RESET;
      regs.closed_threshold    = CLOSED_RESET;
      regs.big_threshold       = BIG_RESET;
      regs.shout_threshold     = SHOUT_RESET;
      regs.reference_deviation = REF_DEV_RESET;
      taken          = 0;
      mag_sum        = '0;
      mag_sq_sum     = '0;
      errors         = 0;
      windows_closed = 0;
      foreach (position_hits[i]) position_hits[i] = 0;
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 100) $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    // Register write; indexes past the list change nothing.
    function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SAMPLE_FORMAT: regs.sample_format       = data[0];
        CFG_WINDOW_LENGTH: regs.window_length       = data[WL_W-1:0];
        CFG_CLOSED:        regs.closed_threshold    = data[THR_W-1:0];
        CFG_BIG:           regs.big_threshold       = data[THR_W-1:0];
        CFG_SHOUT:         regs.shout_threshold     = data[THR_W-1:0];
        CFG_REF_DEV:       regs.reference_deviation = data[REF_W-1:0];
        default: ;
      endcase
    endfunction

    // Accumulates one sample and, at a window end, works out the expected shape.
    function void take_sample(logic [SAMPLE_W-1:0] value, logic clip);
      bit [15:0] mag;
      bit [7:0]  offset;
      bit [63:0] n, s, q, avg, lhs, s2, spread, rhs, scaled;
      bit        lively;
      shape_t    shape;
      if (clip) begin
        taken      = 0;
        mag_sum    = '0;
        mag_sq_sum = '0;
      end
      // Rectify to a Q1.15 magnitude.
      if (regs.sample_format == FORMAT_U8) begin
        offset = (value[7:0] >= U8_BIAS) ? value[7:0] - U8_BIAS : U8_BIAS - value[7:0];
        mag    = offset * U8_SCALE;
      end else if (value[15]) begin
        mag = 16'h0 - value;
      end else begin
        mag = value;
      end
      mag_sum    = mag_sum + 30'(mag);
      mag_sq_sum = mag_sq_sum + 46'(mag) * 46'(mag);
      taken++;
      // Effective window: zero counts as one, long windows saturate.
      if (regs.window_length == '0) n = 64'd1;
      else if (regs.window_length > MAX_N) n = 64'(MAX_N);
      else n = 64'(regs.window_length);
      if (taken < n) return;
      s          = 64'(mag_sum);
      q          = 64'(mag_sq_sum);
      taken      = 0;
      mag_sum    = '0;
      mag_sq_sum = '0;
      avg        = s / n;
      shape.mean = avg[MEAN_W-1:0];
      if (avg < regs.closed_threshold) begin
        shape.position = POS_CLOSED;
      end else if (avg > regs.shout_threshold) begin
        shape.position = POS_SHOUT;
      end else begin
        // Exact variance test, 36*(N*sqsum - sum^2) > 25*ref^2*N^2, in 64-bit words.
        lhs    = n * q;
        s2     = s * s;
        spread = (lhs > s2) ? lhs - s2 : 64'd0;
        rhs    = 64'(regs.reference_deviation) * 64'(regs.reference_deviation);
        rhs    = rhs * n * n * 64'd25;
        scaled = spread * 64'd36;
        lively = scaled > rhs;
        if (avg > regs.big_threshold) shape.position = lively ? POS_BIG_EE : POS_BIG_OH;
        else shape.position = lively ? POS_SMALL_EE : POS_SMALL_OH;
      end
      pending_shapes.push_back(shape);
      windows_closed++;
    endfunction

    task compare_shape(logic [POS_W-1:0] position, logic [MEAN_W-1:0] mean);
      shape_t want;
      if (pending_shapes.size() == 0) begin
        report_mismatch($sformatf("result with no window pending: position %0d mean %0d",
                                  position, mean));
        return;
      end
      want = pending_shapes.pop_front();
      position_hits[want.position]++;
      if (position !== want.position)
        report_mismatch($sformatf("mouth_position %0d, predicted %0d (mean %0d)",
                                  position, want.position, want.mean));
      if (mean !== want.mean)
        report_mismatch($sformatf("window_mean %0d, predicted %0d", mean, want.mean));
    endtask
  endclass

  logic clk;
  logic rst;

  int gap_max       = 13;
  int stall_max     = 13;
  int result_stall  = 0;
  int results_seen  = 0;
  int results_paced = 0;
  int idle_cycles   = 0;
  int samples_sent  = 0;
  int writes_done   = 0;

  mouth_shape_checker shapes = new();

  smsc_sample_if sample_ch ();
  smsc_mouth_if  mouth_ch ();
  smsc_cfg_if    cfg_ch ();

  speech_mouth_shape_classifier DUT (
    .clk   (clk),
    .rst   (rst),
    .sample(sample_ch),
    .mouth (mouth_ch),
    .cfg   (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watch all three channels at the rising edge and keep the watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (mouth_ch.valid && mouth_ch.ready) begin
        shapes.compare_shape(mouth_ch.mouth_position, mouth_ch.window_mean);
        results_seen++;
      end
      if (sample_ch.valid && sample_ch.ready) begin
        shapes.take_sample(sample_ch.sample_value, sample_ch.clip_start);
        samples_sent++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        shapes.apply_write(cfg_ch.index, cfg_ch.data);
        writes_done++;
      end
      if ((mouth_ch.valid && mouth_ch.ready) || (sample_ch.valid && sample_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, idle_cycles);
        $display("speech_mouth_shape_classifier regression: fail");
        $finish;
      end
    end
  end

  // Result side: after each transaction draw a stall, then hold ready low for it.
  always @(negedge clk) begin
    if (results_seen != results_paced) begin
      results_paced = results_seen;
      result_stall  = $urandom_range(0, stall_max);
    end
    if (result_stall > 0) begin
      mouth_ch.ready = 1'b0;
      result_stall--;
    end else begin
      mouth_ch.ready = 1'b1;
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] value, logic clip);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      sample_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_ch.valid        = 1'b1;
    sample_ch.sample_value = value;
    sample_ch.clip_start   = clip;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic configure(logic fmt, logic [CFG_DATA_W-1:0] win, closed, big, shout, dev);
    write_reg(CFG_SAMPLE_FORMAT, CFG_DATA_W'(fmt));
    write_reg(CFG_WINDOW_LENGTH, win);
    write_reg(CFG_CLOSED, closed);
    write_reg(CFG_BIG, big);
    write_reg(CFG_SHOUT, shout);
    write_reg(CFG_REF_DEV, dev);
  endtask

  // Stop sending until every owed result has come, then let the block settle.
  task automatic wait_for_idle(int settle);
    sample_ch.valid = 1'b0;
    while (shapes.pending_shapes.size() != 0) @(posedge clk);
    repeat (settle) @(negedge clk);
    @(negedge clk);
  endtask

  // One randomised phase: fresh settings, idling mode and sample level.
  task automatic random_phase(int items);
    logic                  fmt, clip;
    logic [CFG_DATA_W-1:0] win, closed, big, shout, dev;
    logic [SAMPLE_W-1:0]   value;
    int                    pick, amp, delta, lo;
    fmt  = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 15);
    if (pick == 0) win[WL_W-1:0] = '0;
    else if (pick == 1) win[WL_W-1:0] = WL_W'($urandom_range(41, 300));
    else win[WL_W-1:0] = WL_W'($urandom_range(1, 40));
    win[CFG_DATA_W-1:WL_W] = 2'($urandom_range(0, 3));
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      closed = '1;
      big    = CFG_DATA_W'($urandom);
      shout  = CFG_DATA_W'($urandom);
    end else if (pick == 1) begin
      closed = '0;
      big    = '0;
      shout  = '0;
    end else if (pick == 2) begin
      closed = CFG_DATA_W'($urandom);
      big    = CFG_DATA_W'($urandom);
      shout  = CFG_DATA_W'($urandom);
    end else if (pick == 3) begin
      closed = '0;
      big    = CFG_DATA_W'($urandom);
      shout  = '1;
    end else begin
      closed = CFG_DATA_W'($urandom_range(0, 3000));
      big    = CFG_DATA_W'($urandom_range(2000, 12000));
      shout  = CFG_DATA_W'($urandom_range(9000, 30000));
    end
    pick = $urandom_range(0, 7);
    if (pick == 0) dev = '0;
    else if (pick == 1) dev = '1;
    else if (pick == 2) dev = CFG_DATA_W'($urandom);
    else dev = CFG_DATA_W'($urandom_range(0, 12000));
    configure(fmt, win, closed, big, shout, dev);
    if ($urandom_range(0, 5) == 0) write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                                             CFG_DATA_W'($urandom));

    // Idling mode for both sides: busy, light or none.
    pick      = $urandom_range(0, 3);
    gap_max   = (pick == 0) ? 0 : (pick == 1) ? 3 : 13;
    pick      = $urandom_range(0, 3);
    stall_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 13;
    amp       = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4000) : $urandom_range(0, 32767);

    for (int i = 0; i < items; i++) begin
      clip = (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 31) == 0);
      if ($urandom_range(0, 9) == 0) begin
        value = SAMPLE_W'($urandom);
      end else if (fmt == FORMAT_S16) begin
        value = SAMPLE_W'($urandom_range(0, amp));
        if ($urandom_range(0, 1)) value = -value;
      end else begin
        delta      = $urandom_range(0, amp >> 8);
        lo         = $urandom_range(0, 1) ? int'(U8_BIAS) + delta : int'(U8_BIAS) - delta;
        value      = SAMPLE_W'($urandom);
        value[7:0] = 8'(lo);
      end
      if ($urandom_range(0, 149) == 0) wait_for_idle(0);
      send_sample(value, clip);
    end
  endtask

  initial begin
    int random_sent;
    clk                    = 1'b0;
    rst                    = 1'b1;
    sample_ch.valid        = 1'b0;
    sample_ch.sample_value = '0;
    sample_ch.clip_start   = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.index           = '0;
    cfg_ch.data            = '0;
    random_sent            = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Sixteen-bit extremes, one sample per window.
    configure(FORMAT_S16, 15'd1, 15'd0, 15'd16384, 15'h7FFF, 15'd0);
    foreach (WIDE_EXTREMES[i]) send_sample(WIDE_EXTREMES[i], 1'b0);

    // Eight-bit extremes with junk in the upper byte, plus writes to spare indexes.
    wait_for_idle(SETTLE_CYCLES);
    write_reg(CFG_SAMPLE_FORMAT, CFG_DATA_W'(FORMAT_U8));
    write_reg(CFG_CLOSED, 15'd300);
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, 15'h1234);
    foreach (BYTE_EXTREMES[i]) send_sample(BYTE_EXTREMES[i], 1'b0);

    // A zero window length behaves as a length of one.
    wait_for_idle(SETTLE_CYCLES);
    write_reg(CFG_WINDOW_LENGTH, 15'd0);
    send_sample(16'h00C0, 1'b0);
    send_sample(16'h0010, 1'b0);

    // Pairs with and without spread, then a clip start part-way through a window.
    wait_for_idle(SETTLE_CYCLES);
    write_reg(CFG_SAMPLE_FORMAT, CFG_DATA_W'(FORMAT_S16));
    write_reg(CFG_WINDOW_LENGTH, 15'd2);
    send_sample(16'd1000, 1'b0);
    send_sample(-16'sd3000, 1'b0);
    send_sample(16'd2000, 1'b0);
    send_sample(16'd2000, 1'b0);
    send_sample(16'd5000, 1'b0);
    send_sample(16'd100, 1'b1);
    send_sample(16'd200, 1'b0);

    // Window shortened below the count already taken: it ends on the next sample.
    wait_for_idle(SETTLE_CYCLES);
    write_reg(CFG_WINDOW_LENGTH, 15'd10);
    repeat (4) send_sample(16'($urandom), 1'b0);
    wait_for_idle(SETTLE_CYCLES);
    write_reg(CFG_WINDOW_LENGTH, 15'd2);
    send_sample(16'd7000, 1'b0);

    // Randomised phases until enough samples have gone through.
    while (random_sent < RANDOM_ITEMS) begin
      wait_for_idle(SETTLE_CYCLES);
      pick_items: begin
        int items;
        items = $urandom_range(20, 160);
        random_phase(items);
        random_sent += items;
      end
    end

    // Over-range lengths saturate, so no window closes on their low bits: first the
    // largest value, then just above the maximum. A short length then ends the window
    // with a mean too wide for its field.
    wait_for_idle(SETTLE_CYCLES);
    gap_max   = 2;
    stall_max = 13;
    configure(FORMAT_S16, 15'h1FFF, 15'd500, 15'd4000, 15'd20000, 15'd3000);
    for (int i = 0; i < LONG_PROBE; i++) send_sample(16'($urandom_range(0, 12000)), i == 0);
    wait_for_idle(SETTLE_CYCLES);
    write_reg(CFG_WINDOW_LENGTH, CFG_DATA_W'(MAX_N + 5));
    for (int i = 0; i < LONG_PROBE; i++) send_sample(16'($urandom_range(0, 12000)), 1'b0);
    wait_for_idle(SETTLE_CYCLES);
    write_reg(CFG_WINDOW_LENGTH, 15'd2);
    send_sample(16'd9000, 1'b0);

    // The maximum length itself in eight-bit format, ended the same way.
    wait_for_idle(SETTLE_CYCLES);
    configure(FORMAT_U8, 15'h7000, 15'd1000, 15'd8000, 15'd25000, 15'd6000);
    for (int i = 0; i < LONG_PROBE; i++) send_sample(16'($urandom), i == 0);
    wait_for_idle(SETTLE_CYCLES);
    write_reg(CFG_WINDOW_LENGTH, 15'd3);
    send_sample(16'($urandom), 1'b0);

    wait_for_idle(SETTLE_CYCLES);
    if (shapes.pending_shapes.size() != 0)
      shapes.report_mismatch($sformatf("%0d results never arrived",
                                       shapes.pending_shapes.size()));

    $display("Covered %0d samples in both formats, %0d windows, %0d register writes.",
             samples_sent, shapes.windows_closed, writes_done);
    $display("Positions: closed %0d, small oh %0d, small ee %0d, big oh %0d, big ee %0d, shout %0d",
             shapes.position_hits[POS_CLOSED], shapes.position_hits[POS_SMALL_OH],
             shapes.position_hits[POS_SMALL_EE], shapes.position_hits[POS_BIG_OH],
             shapes.position_hits[POS_BIG_EE], shapes.position_hits[POS_SHOUT]);
    if (shapes.errors == 0) begin
      $display("speech_mouth_shape_classifier regression: pass");
    end else begin
      $display("speech_mouth_shape_classifier regression: fail");
    end
    $finish;
  end
endmodule
